### sv/afbu_pkg.sv
// afbu_pkg: shared types, constants and the tanh breakpoint table for the
// activation forward/backward unit
// no dependencies
package afbu_pkg;

  // number format
  localparam int FRAC_BITS      = 12;
  localparam int TABLE_SEGMENTS = 64;
  localparam int SEG_W          = $clog2(TABLE_SEGMENTS);
  localparam int LEAK_FRAC      = 12;
  localparam int Q24_SHIFT      = 24;
  localparam int TANH_FB        = FRAC_BITS + 1;
  localparam int SPAN_SHIFT     = TANH_FB + 3;
  localparam int SPAN2          = 1 << SPAN_SHIFT;
  localparam int ONE            = 1 << FRAC_BITS;

  // gelu constants in q24
  localparam logic signed [24:0] C_SQRT2PI = 25'sd13386282;
  localparam logic signed [20:0] C_CUBIC   = 21'sd750193;
  localparam logic signed [22:0] C_CUBIC3  = 23'sd2250579;

  localparam logic [63:0] ONE31 = 64'h0000_0000_8000_0000;

  // operation codes
  typedef enum logic [3:0] {
    MODE_RELU_FWD  = 4'd0,
    MODE_RELU_BWD  = 4'd1,
    MODE_LEAKY_FWD = 4'd2,
    MODE_LEAKY_BWD = 4'd3,
    MODE_GELU_FWD  = 4'd4,
    MODE_GELU_BWD  = 4'd5,
    MODE_SIGM_FWD  = 4'd6,
    MODE_SIGM_BWD  = 4'd7,
    MODE_TANH_FWD  = 4'd8,
    MODE_TANH_BWD  = 4'd9
  } mode_e;

  // request and result payloads
  typedef struct packed {
    logic [3:0]         mode;
    logic signed [15:0] operand;
    logic signed [15:0] upstream_grad;
  } afbu_in_t;

  typedef struct packed {
    logic signed [15:0] result;
    logic               saturated;
  } afbu_out_t;

  typedef logic signed [15:0] rom_t [0:TABLE_SEGMENTS];

  // round to nearest, halves away from zero, divide by 2^k
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] n,
                                                 input int unsigned k);
    logic signed [63:0] h;
    h = 64'sd1 <<< (k - 1);
    if (n >= 0) begin
      return (n + h) >>> k;
    end
    return -((-n + h) >>> k);
  endfunction

  // unsigned long division by shift and subtract, used only while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh breakpoints at x = 8k/TABLE_SEGMENTS, exp(-2x) in q31
  function automatic rom_t build_tanh_rom();
    rom_t               rom;
    logic [63:0]        z;
    logic [63:0]        term;
    logic [63:0]        e;
    logic [63:0]        num;
    logic [63:0]        den;
    logic signed [63:0] sum;
    for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
      z    = udiv64(64'(k) << 31, 64'(2 * TABLE_SEGMENTS));
      term = ONE31;
      sum  = $signed(ONE31);
      for (int n = 1; n <= 16; n++) begin
        term = udiv64((term * z) >> 31, 64'(n));
        if ((n & 1) != 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        e = 64'd0;
      end else begin
        e = $unsigned(sum);
      end
      if (e > ONE31) begin
        e = ONE31;
      end
      for (int i = 0; i < 5; i++) begin
        e = (e * e) >> 31;
      end
      num = (ONE31 - e) << FRAC_BITS;
      den = ONE31 + e;
      rom[k] = 16'(udiv64(num + (den >> 1), den));
    end
    return rom;
  endfunction

  localparam rom_t TANH_ROM = build_tanh_rom();

endpackage

### sv/activation_forward_backward_unit_core.sv
// activation_forward_backward_unit_core: pipelined relu / leaky relu / gelu /
// sigmoid / tanh forward and backward unit
// depends on afbu_pkg
//
// One request per clock: busy is always low and a request is taken at every
// edge where start is high. Each result appears on out_res for one cycle with
// out_valid high, in request order; the receiver cannot stall and nothing is
// buffered. The pipe has twenty stages plus the output register that clips
// to 16 bits: the gelu backward path has nine dependent multiplies, each in
// a stage of its own and followed by a stage that rounds its product, plus
// one add stage for the tanh argument and one segment-select stage ahead of
// the tanh table read.
// Values are signed Q3.12 with round-to-nearest and saturation, flagged on
// out_res.saturated. Write leak_slope (cfg_we/cfg_wdata) only while no
// request is in flight.
module activation_forward_backward_unit_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  afbu_pkg::afbu_in_t    in_req,
  output logic                  out_valid,
  output afbu_pkg::afbu_out_t   out_res,
  input  logic                  cfg_we,
  input  logic [12:0]           cfg_wdata
);
  import afbu_pkg::*;

  localparam int NS      = 20;
  localparam int LATENCY = NS + 1;

  // configuration
  logic [12:0] leak_slope_r;

  // fields carried down the pipe
  logic               vld_r   [1:NS];
  logic               vld_nxt [1:NS];
  logic [3:0]         mode_r  [1:NS];
  logic [3:0]         mode_nxt[1:NS];
  logic signed [15:0] x_r     [1:NS];
  logic signed [15:0] x_nxt   [1:NS];
  logic signed [15:0] g_r     [1:NS];
  logic signed [15:0] g_nxt   [1:NS];
  logic signed [31:0] res_r   [2:NS];
  logic signed [31:0] res_nxt [2:NS];
  logic signed [17:0] du_r    [7:16];
  logic signed [17:0] du_nxt  [7:16];
  logic signed [15:0] t_r     [12:15];
  logic signed [15:0] t_nxt   [12:15];

  // stage registers
  logic signed [31:0] xx1_r, xx1_nxt;
  logic signed [31:0] gx1_r, gx1_nxt;
  logic signed [29:0] lkp1_r, lkp1_nxt;
  logic signed [18:0] x2_2_r, x2_2_nxt;
  logic signed [48:0] sbp2_r, sbp2_nxt;
  logic signed [32:0] om2_2_r, om2_2_nxt;
  logic signed [33:0] x3p3_r, x3p3_nxt;
  logic signed [40:0] dup3_r, dup3_nxt;
  logic signed [48:0] tbp3_r, tbp3_nxt;
  logic signed [21:0] x3_4_r, x3_4_nxt;
  logic signed [16:0] dua4_r, dua4_nxt;
  logic signed [42:0] c3p5_r, c3p5_nxt;
  logic signed [16:0] dub5_r, dub5_nxt;
  logic signed [19:0] c3_6_r, c3_6_nxt;
  logic signed [41:0] dup6_r, dup6_nxt;
  logic signed [19:0] us7_r, us7_nxt;
  logic signed [44:0] up8_r, up8_nxt;
  logic signed [20:0] u9_r, u9_nxt;
  logic               neg10_r, neg10_nxt;
  logic               sat10_r, sat10_nxt;
  logic [SEG_W-1:0]   seg10_r, seg10_nxt;
  logic [SPAN_SHIFT-1:0] frac10_r, frac10_nxt;
  logic               neg11_r, neg11_nxt;
  logic               sat11_r, sat11_nxt;
  logic signed [15:0] lo11_r, lo11_nxt;
  logic signed [34:0] prod11_r, prod11_nxt;
  logic signed [32:0] fp13_r, fp13_nxt;
  logic signed [31:0] tt13_r, tt13_nxt;
  logic signed [15:0] s2_14_r, s2_14_nxt;
  logic signed [31:0] xs2p15_r, xs2p15_nxt;
  logic signed [17:0] xs2_16_r, xs2_16_nxt;
  logic signed [15:0] h16_r, h16_nxt;
  logic signed [35:0] dp17_r, dp17_nxt;
  logic signed [15:0] h17_r, h17_nxt;
  logic signed [19:0] d18_r, d18_nxt;
  logic signed [35:0] gdp19_r, gdp19_nxt;

  logic               out_valid_r;
  afbu_out_t          out_res_r, out_res_nxt;

  // combinational temporaries
  logic signed [15:0] lk_sel;
  logic signed [13:0] slope_s;
  logic signed [16:0] om_x;
  logic               pos1;
  logic signed [21:0] tsrc;
  logic [23:0]        tmag;
  logic [23:0]        am;
  logic [39:0]        tp;
  logic [SEG_W:0]     idx_lo;
  logic [SEG_W:0]     idx_hi;
  logic signed [16:0] tdiff;
  logic signed [15:0] tv;
  logic signed [16:0] onept;
  logic               is_gelu9;

  assign busy = 1'b0;

  always_comb begin
    // pipe shifting defaults
    vld_nxt[1]  = start && !busy;
    mode_nxt[1] = in_req.mode;
    x_nxt[1]    = in_req.operand;
    g_nxt[1]    = in_req.upstream_grad;
    for (int k = 2; k <= NS; k++) begin
      vld_nxt[k]  = vld_r[k-1];
      mode_nxt[k] = mode_r[k-1];
      x_nxt[k]    = x_r[k-1];
      g_nxt[k]    = g_r[k-1];
    end
    for (int k = 3; k <= NS; k++) begin
      res_nxt[k] = res_r[k-1];
    end
    for (int k = 8; k <= 16; k++) begin
      du_nxt[k] = du_r[k-1];
    end
    for (int k = 13; k <= 15; k++) begin
      t_nxt[k] = t_r[k-1];
    end

    // stage 1: first products
    slope_s  = $signed({1'b0, leak_slope_r});
    lk_sel   = (in_req.mode == MODE_LEAKY_BWD) ? in_req.upstream_grad : in_req.operand;
    xx1_nxt  = in_req.operand * in_req.operand;
    gx1_nxt  = in_req.upstream_grad * in_req.operand;
    lkp1_nxt = lk_sel * slope_s;

    // stage 2: relu and leaky results, x^2, sigmoid backward product, 1 - x^2 for tanh backward
    pos1      = x_r[1] > 16'sd0;
    om_x      = 17'(ONE) - 17'(x_r[1]);
    x2_2_nxt  = 19'(rnd_shr(64'(xx1_r), FRAC_BITS));
    sbp2_nxt  = gx1_r * om_x;
    om2_2_nxt = 33'(64'sd1 <<< (2 * FRAC_BITS)) - 33'(xx1_r);
    case (mode_r[1])
      MODE_RELU_FWD:  res_nxt[2] = pos1 ? 32'(x_r[1]) : 32'sd0;
      MODE_RELU_BWD:  res_nxt[2] = pos1 ? 32'(g_r[1]) : 32'sd0;
      MODE_LEAKY_FWD: res_nxt[2] = pos1 ? 32'(x_r[1])
                                        : 32'(rnd_shr(64'(lkp1_r), LEAK_FRAC));
      MODE_LEAKY_BWD: res_nxt[2] = pos1 ? 32'(g_r[1])
                                        : 32'(rnd_shr(64'(lkp1_r), LEAK_FRAC));
      default:        res_nxt[2] = 32'sd0;
    endcase

    // stage 3: x^3 product, du cubic term, tanh backward product, sigmoid backward result
    x3p3_nxt = x2_2_r * x_r[2];
    dup3_nxt = x2_2_r * C_CUBIC3;
    tbp3_nxt = g_r[2] * om2_2_r;
    if (mode_r[2] == MODE_SIGM_BWD) begin
      res_nxt[3] = 32'(rnd_shr(64'(sbp2_r), 2 * FRAC_BITS));
    end

    // stage 4: round x^3 and du term, tanh backward result
    x3_4_nxt = 22'(rnd_shr(64'(x3p3_r), FRAC_BITS));
    dua4_nxt = 17'(rnd_shr(64'(dup3_r), Q24_SHIFT));
    if (mode_r[3] == MODE_TANH_BWD) begin
      res_nxt[4] = 32'(rnd_shr(64'(tbp3_r), 2 * FRAC_BITS));
    end

    // stage 5: cubic term product, 1 + du cubic term
    c3p5_nxt = C_CUBIC * x3_4_r;
    dub5_nxt = 17'(ONE) + dua4_r;

    // stage 6
    c3_6_nxt = 20'(rnd_shr(64'(c3p5_r), Q24_SHIFT));
    dup6_nxt = C_SQRT2PI * dub5_r;

    // stage 7: inner sum, du final
    us7_nxt   = 20'(x_r[6]) + c3_6_r;
    du_nxt[7] = 18'(rnd_shr(64'(dup6_r), Q24_SHIFT));

    // stage 8
    up8_nxt = C_SQRT2PI * us7_r;

    // stage 9: tanh argument for gelu
    u9_nxt = 21'(rnd_shr(64'(up8_r), Q24_SHIFT));

    // stage 10: tanh segment select, all inputs read with one extra fraction bit
    is_gelu9 = (mode_r[9] == MODE_GELU_FWD) || (mode_r[9] == MODE_GELU_BWD);
    tsrc     = is_gelu9 ? 22'(u9_r) : 22'(x_r[9]);
    tmag     = tsrc[21] ? 24'(-tsrc) : 24'(tsrc);
    am       = (mode_r[9] == MODE_SIGM_FWD) ? tmag : (tmag << 1);
    tp       = 40'(am) * 40'(TABLE_SEGMENTS);
    neg10_nxt  = tsrc[21];
    sat10_nxt  = am >= 24'(SPAN2);
    seg10_nxt  = sat10_nxt ? '0 : tp[SPAN_SHIFT +: SEG_W];
    frac10_nxt = tp[SPAN_SHIFT-1:0];

    // stage 11: table read and slope product
    idx_lo     = {1'b0, seg10_r};
    idx_hi     = idx_lo + 1'b1;
    lo11_nxt   = TANH_ROM[idx_lo];
    tdiff      = 17'(TANH_ROM[idx_hi]) - 17'(TANH_ROM[idx_lo]);
    prod11_nxt = tdiff * $signed({1'b0, frac10_r});
    neg11_nxt  = neg10_r;
    sat11_nxt  = sat10_r;

    // stage 12: interpolate, saturate, restore sign
    tv = sat11_r ? 16'(ONE) : 16'(64'(lo11_r) + rnd_shr(64'(prod11_r), SPAN_SHIFT));
    t_nxt[12] = neg11_r ? -tv : tv;

    // stage 13: sigmoid and tanh results, gelu products
    onept    = 17'(ONE) + 17'(t_r[12]);
    fp13_nxt = x_r[12] * onept;
    tt13_nxt = t_r[12] * t_r[12];
    if (mode_r[12] == MODE_SIGM_FWD) begin
      res_nxt[13] = 32'(rnd_shr(64'(onept), 1));
    end else if (mode_r[12] == MODE_TANH_FWD) begin
      res_nxt[13] = 32'(t_r[12]);
    end

    // stage 14: gelu forward result, 1 - t^2
    s2_14_nxt = 16'(ONE) - 16'(rnd_shr(64'(tt13_r), FRAC_BITS));
    if (mode_r[13] == MODE_GELU_FWD) begin
      res_nxt[14] = 32'(rnd_shr(64'(fp13_r), FRAC_BITS + 1));
    end

    // stage 15
    xs2p15_nxt = x_r[14] * s2_14_r;

    // stage 16
    xs2_16_nxt = 18'(rnd_shr(64'(xs2p15_r), FRAC_BITS));
    h16_nxt    = 16'(rnd_shr(64'(17'(ONE) + 17'(t_r[15])), 1));

    // stage 17
    dp17_nxt = xs2_16_r * du_r[16];
    h17_nxt  = h16_r;

    // stage 18: gelu derivative
    d18_nxt = 20'(h17_r) + 20'(rnd_shr(64'(dp17_r), FRAC_BITS + 1));

    // stage 19
    gdp19_nxt = g_r[18] * d18_r;

    // stage 20: gelu backward result
    if (mode_r[19] == MODE_GELU_BWD) begin
      res_nxt[20] = 32'(rnd_shr(64'(gdp19_r), FRAC_BITS));
    end

    // output: clip to 16 bits
    if (res_r[NS] > 32'sd32767) begin
      out_res_nxt.result    = 16'sh7fff;
      out_res_nxt.saturated = 1'b1;
    end else if (res_r[NS] < -32'sd32768) begin
      out_res_nxt.result    = 16'sh8000;
      out_res_nxt.saturated = 1'b1;
    end else begin
      out_res_nxt.result    = res_r[NS][15:0];
      out_res_nxt.saturated = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_slope_r <= 13'd41;
      out_valid_r  <= 1'b0;
      for (int k = 1; k <= NS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        leak_slope_r <= cfg_wdata;
      end
      out_valid_r <= vld_r[NS];
      vld_r       <= vld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    x_r       <= x_nxt;
    g_r       <= g_nxt;
    res_r     <= res_nxt;
    du_r      <= du_nxt;
    t_r       <= t_nxt;
    xx1_r     <= xx1_nxt;
    gx1_r     <= gx1_nxt;
    lkp1_r    <= lkp1_nxt;
    x2_2_r    <= x2_2_nxt;
    sbp2_r    <= sbp2_nxt;
    om2_2_r   <= om2_2_nxt;
    x3p3_r    <= x3p3_nxt;
    dup3_r    <= dup3_nxt;
    tbp3_r    <= tbp3_nxt;
    x3_4_r    <= x3_4_nxt;
    dua4_r    <= dua4_nxt;
    c3p5_r    <= c3p5_nxt;
    dub5_r    <= dub5_nxt;
    c3_6_r    <= c3_6_nxt;
    dup6_r    <= dup6_nxt;
    us7_r     <= us7_nxt;
    up8_r     <= up8_nxt;
    u9_r      <= u9_nxt;
    neg10_r   <= neg10_nxt;
    sat10_r   <= sat10_nxt;
    seg10_r   <= seg10_nxt;
    frac10_r  <= frac10_nxt;
    neg11_r   <= neg11_nxt;
    sat11_r   <= sat11_nxt;
    lo11_r    <= lo11_nxt;
    prod11_r  <= prod11_nxt;
    fp13_r    <= fp13_nxt;
    tt13_r    <= tt13_nxt;
    s2_14_r   <= s2_14_nxt;
    xs2p15_r  <= xs2p15_nxt;
    xs2_16_r  <= xs2_16_nxt;
    h16_r     <= h16_nxt;
    dp17_r    <= dp17_nxt;
    h17_r     <= h17_nxt;
    d18_r     <= d18_nxt;
    gdp19_r   <= gdp19_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // every request comes out a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("result missing at expected latency");

  // a clipped result sits on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.saturated |->
      (out_res.result == 16'sh7fff) || (out_res.result == 16'sh8000))
    else $error("saturated result not at a rail");

  // unused modes give a clean zero
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req.mode > MODE_TANH_BWD) |->
      ##LATENCY (out_res.result == 16'sd0) && !out_res.saturated)
    else $error("unused mode produced nonzero result");

  // relu forward is never negative
  a_relu_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req.mode == MODE_RELU_FWD) |->
      ##LATENCY !out_res.result[15])
    else $error("relu forward result negative");

endmodule
